### rtl/marker_frame_hex_formatter_defines.svh
// ----------------------------------------------------------------------------
// Marker frame hex formatter assertion macros
// Concurrent check macros used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MARKER_FRAME_HEX_FORMATTER_DEFINES_SVH
`define MARKER_FRAME_HEX_FORMATTER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MFHF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MFHF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MFHF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MFHF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/mfhf_pkg.sv
// ----------------------------------------------------------------------------
// Marker frame hex formatter package
// Status codes, register indexes, shared structs and the hex digit function.
// ----------------------------------------------------------------------------
package mfhf_pkg;

	localparam int MAX_ADDR_W = 8;
	localparam int CFG_IDX_W  = 8;

	typedef logic [1:0] status_t;
	localparam status_t ST_BYTE     = 2'd0;
	localparam status_t ST_TOO_LONG = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd1;

	localparam logic [7:0] START_MARKER_RST = 8'h55;
	localparam logic [7:0] END_MARKER_RST   = 8'hDD;

	localparam logic [6:0] ASCII_ZERO = 7'd48;
	localparam logic [6:0] ASCII_A    = 7'd65;

	typedef enum logic {
		RD_IDLE,
		RD_ISSUE
	} rd_state_t;

	// store write request
	typedef struct packed {
		logic                  en;
		logic [MAX_ADDR_W-1:0] addr;
		logic [7:0]            data;
	} wr_req_t;

	// frame close event
	typedef struct packed {
		logic                  empty;
		logic                  too_long;
		logic                  burst;
		logic [MAX_ADDR_W-1:0] count;
	} frame_ev_t;

	function automatic logic [6:0] hex_digit(input logic [3:0] nib);
		logic [6:0] d;
		if (nib < 4'd10) begin
			d = ASCII_ZERO + {3'd0, nib};
		end else begin
			d = ASCII_A + {3'd0, nib - 4'd10};
		end
		return d;
	endfunction

endpackage

### rtl/mfhf_cfg_if.sv
// ----------------------------------------------------------------------------
// Marker frame hex formatter configuration channel
// Register write transfers: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface mfhf_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/mfhf_rx_if.sv
// ----------------------------------------------------------------------------
// Marker frame hex formatter byte input channel
// One received byte per transfer.
// ----------------------------------------------------------------------------
interface mfhf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/mfhf_res_if.sv
// ----------------------------------------------------------------------------
// Marker frame hex formatter result channel
// One formatted payload byte or frame status per transfer.
// ----------------------------------------------------------------------------
interface mfhf_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [7:0] payload_byte;
	logic [6:0] hex_high;
	logic [6:0] hex_low;
	logic [2:0] row;
	logic [2:0] column;
	logic       last;

	modport source (output valid, output status, output payload_byte, output hex_high,
		output hex_low, output row, output column, output last, input ready);
	modport sink (input valid, input status, input payload_byte, input hex_high,
		input hex_low, input row, input column, input last, output ready);
endinterface

### rtl/mfhf_deframer.sv
// ----------------------------------------------------------------------------
// Marker frame deframer
// Tracks the open frame, issues store writes and flags frame closes.
// ----------------------------------------------------------------------------
module mfhf_deframer #(
	parameter int FRAME_DEPTH   = 64,
	parameter int BYTES_PER_ROW = 8,
	parameter int DISPLAY_ROWS  = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_take,
	input  logic [7:0]         byte_in,
	input  logic [7:0]         start_marker,
	input  logic [7:0]         end_marker,
	output mfhf_pkg::wr_req_t  wr,
	output mfhf_pkg::frame_ev_t ev
);
	import mfhf_pkg::*;

	localparam int AW        = $clog2(FRAME_DEPTH);
	localparam int MAX_SHOWN = DISPLAY_ROWS * BYTES_PER_ROW;

	logic          receiving_q, receiving_d;
	logic [AW-1:0] fill_q, fill_d;
	logic [AW-1:0] payload;

	always_comb begin
		receiving_d = receiving_q;
		fill_d      = fill_q;
		wr          = '0;
		ev          = '0;
		payload     = fill_q - AW'(1);
		wr.data     = byte_in;
		if (byte_take) begin
			if (byte_in == start_marker) begin
				// restart, dropping any frame in progress
				wr.en       = 1'b1;
				wr.addr     = '0;
				fill_d      = AW'(1);
				receiving_d = 1'b1;
			end else if (receiving_q) begin
				if (byte_in != end_marker) begin
					if (fill_q < AW'(FRAME_DEPTH - 1)) begin
						wr.en   = 1'b1;
						wr.addr = MAX_ADDR_W'(fill_q);
						fill_d  = fill_q + AW'(1);
					end
				end else begin
					receiving_d = 1'b0;
					fill_d      = '0;
					// full store or no start byte: drop the frame
					if (fill_q < AW'(FRAME_DEPTH - 1) && fill_q != '0) begin
						if (payload == '0) begin
							ev.empty = 1'b1;
						end else if (int'(payload) > MAX_SHOWN) begin
							ev.too_long = 1'b1;
						end else begin
							ev.burst = 1'b1;
							ev.count = MAX_ADDR_W'(payload);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			fill_q      <= '0;
		end else begin
			receiving_q <= receiving_d;
			fill_q      <= fill_d;
		end
	end

endmodule

### rtl/marker_frame_hex_formatter.sv
// ----------------------------------------------------------------------------
// Marker frame hex formatter
// Deframes start/end marked byte frames and reads them out as hex results.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while no frame is being read out and the
// result register is free or emptying. A closed frame of N displayable
// payload bytes is read from the store at one entry per cycle while the
// sink keeps up; each entry is registered as read data, then as a result.
// The input stalls until the last entry leaves the read data register; the
// single port read with registered data sets this pace. Empty and too-long
// frames give one result in the cycle after the end marker. The store has
// no reset; only entries written in the current frame are read. Marker
// registers must be written only while idle; the block does not check it.
`include "marker_frame_hex_formatter_defines.svh"

module marker_frame_hex_formatter #(
	parameter int FRAME_DEPTH   = 64,
	parameter int BYTES_PER_ROW = 8,
	parameter int DISPLAY_ROWS  = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	mfhf_cfg_if.sink    cfg,
	mfhf_rx_if.sink     rx,
	mfhf_res_if.source  res
);
	import mfhf_pkg::*;

	localparam int AW = $clog2(FRAME_DEPTH);
	localparam int CW = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;

	// configuration
	logic [7:0] start_marker_q, end_marker_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_START_MARKER: start_marker_q <= cfg.data;
				CFG_END_MARKER:   end_marker_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// handshake control
	rd_state_t  state_q, state_d;
	logic       out_valid_q;
	logic       s1_valid;
	logic       out_free;
	logic       load_out;
	logic       rd_en;
	logic       byte_take;
	wr_req_t    wr;
	frame_ev_t  ev;

	assign out_free  = !out_valid_q || res.ready;
	assign load_out  = s1_valid && out_free;
	assign rx.ready  = (state_q == RD_IDLE) && !s1_valid && out_free;
	assign byte_take = rx.valid && rx.ready;

	mfhf_deframer #(
		.FRAME_DEPTH  (FRAME_DEPTH),
		.BYTES_PER_ROW(BYTES_PER_ROW),
		.DISPLAY_ROWS (DISPLAY_ROWS)
	) u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_take   (byte_take),
		.byte_in     (rx.rx_byte),
		.start_marker(start_marker_q),
		.end_marker  (end_marker_q),
		.wr          (wr),
		.ev          (ev)
	);

	// readout sequencer
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] remain_q;
	logic [2:0]    row_q;
	logic [CW-1:0] col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		case (state_q)
			RD_IDLE: begin
				if (ev.burst) begin
					state_d = RD_ISSUE;
				end
			end
			RD_ISSUE: begin
				rd_en = !s1_valid || load_out;
				if (rd_en && remain_q == AW'(1)) begin
					state_d = RD_IDLE;
				end
			end
			default: state_d = RD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ev.burst) begin
			rd_addr_q <= AW'(1);
			remain_q  <= ev.count[AW-1:0];
			row_q     <= '0;
			col_q     <= '0;
		end else if (rd_en) begin
			rd_addr_q <= rd_addr_q + AW'(1);
			remain_q  <= remain_q - AW'(1);
			if (col_q == CW'(BYTES_PER_ROW - 1)) begin
				col_q <= '0;
				row_q <= row_q + 3'd1;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// frame store, read data registered
	logic [7:0] frame_store [FRAME_DEPTH];
	logic [7:0] rd_data_s1;
	logic [2:0] row_s1;
	logic [2:0] col_s1;
	logic       last_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			frame_store[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			rd_data_s1 <= frame_store[rd_addr_q];
			row_s1     <= row_q;
			col_s1     <= 3'(col_q);
			last_s1    <= (remain_q == AW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (rd_en) begin
			s1_valid <= 1'b1;
		end else if (load_out) begin
			s1_valid <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out || ev.empty || ev.too_long) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res.status       <= ST_BYTE;
			res.payload_byte <= rd_data_s1;
			res.hex_high     <= hex_digit(rd_data_s1[7:4]);
			res.hex_low      <= hex_digit(rd_data_s1[3:0]);
			res.row          <= row_s1;
			res.column       <= col_s1;
			res.last         <= last_s1;
		end else if (ev.empty || ev.too_long) begin
			res.status       <= ev.empty ? ST_EMPTY : ST_TOO_LONG;
			res.payload_byte <= '0;
			res.hex_high     <= ASCII_ZERO;
			res.hex_low      <= ASCII_ZERO;
			res.row          <= '0;
			res.column       <= '0;
			res.last         <= 1'b1;
		end
	end

	assign res.valid = out_valid_q;

	// checks
	`MFHF_ASSERT_IMP(a_rd_in_range, clk, arst_n, rd_en, remain_q != '0,
		"store read issued with no bytes left")
	`MFHF_ASSERT_NXT(a_s1_hold, clk, arst_n, s1_valid && !out_free,
		s1_valid && $stable(rd_data_s1) && $stable(last_s1),
		"read data lost while result register stalled")
	`MFHF_ASSERT_NXT(a_burst_start, clk, arst_n, ev.burst,
		state_q == RD_ISSUE && !s1_valid, "frame readout did not start")
	`MFHF_ASSERT_IMP(a_status_last, clk, arst_n, out_valid_q && res.status != ST_BYTE,
		res.last, "status result without last flag")

endmodule

### verif/marker_frame_hex_formatter_checker.sv
// ----------------------------------------------------------------------------
// Marker frame hex formatter checker
// Watches the register, byte and result channels, predicts the formatted
// results of every closed frame and compares each result transfer in order.
// ----------------------------------------------------------------------------
module marker_frame_hex_formatter_checker #(
	parameter int FRAME_DEPTH   = 64,
	parameter int BYTES_PER_ROW = 8,
	parameter int DISPLAY_ROWS  = 5
) (
	input  logic  clk,
	input  logic  arst_n,
	mfhf_cfg_if   cfg,
	mfhf_rx_if    rx,
	mfhf_res_if   res,
	output int    fails,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import mfhf_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [7:0] payload_byte;
		logic [6:0] hex_high;
		logic [6:0] hex_low;
		logic [2:0] row;
		logic [2:0] column;
		logic       last;
	} hex_result_t;

	// digit characters, first character in the top byte
	localparam logic [127:0] DIGIT_CHARS = "0123456789ABCDEF";

	logic [7:0]  start_code;
	logic [7:0]  end_code;
	bit          frame_open;
	int unsigned fill;
	logic [7:0]  frame_bytes [FRAME_DEPTH];
	hex_result_t expected_results [$];

	function automatic logic [6:0] digit_char(input logic [3:0] nib);
		logic [7:0] c;
		c = DIGIT_CHARS[(15 - nib) * 8 +: 8];
		return c[6:0];
	endfunction

	function automatic hex_result_t frame_status(input status_t st);
		hex_result_t r;
		r = '0;
		r.status   = st;
		r.hex_high = ASCII_ZERO;
		r.hex_low  = ASCII_ZERO;
		r.last     = 1'b1;
		return r;
	endfunction

	task automatic take_byte(input logic [7:0] b);
		int unsigned payload;
		hex_result_t r;
		if (b == start_code) begin
			frame_bytes[0] = b;
			fill = 1;
			frame_open = 1'b1;
			return;
		end
		if (!frame_open)
			return;
		if (b != end_code) begin
			// drop bytes once the store is full
			if (fill < FRAME_DEPTH - 1) begin
				frame_bytes[fill] = b;
				fill++;
			end
			return;
		end
		frame_open = 1'b0;
		if (fill >= FRAME_DEPTH - 1 || fill == 0) begin
			fill = 0;
			return;
		end
		payload = fill - 1;
		fill = 0;
		if (payload == 0) begin
			expected_results.push_back(frame_status(ST_EMPTY));
		end else if (payload > DISPLAY_ROWS * BYTES_PER_ROW) begin
			expected_results.push_back(frame_status(ST_TOO_LONG));
		end else begin
			for (int unsigned k = 0; k < payload; k++) begin
				r.status       = ST_BYTE;
				r.payload_byte = frame_bytes[(k + 1) % FRAME_DEPTH];
				r.hex_high     = digit_char(r.payload_byte[7:4]);
				r.hex_low      = digit_char(r.payload_byte[3:0]);
				r.row          = 3'(k / BYTES_PER_ROW);
				r.column       = 3'(k % BYTES_PER_ROW);
				r.last         = (k + 1 == payload);
				expected_results.push_back(r);
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got, inout int errs);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			errs++;
		end
	endtask

	task automatic check_result();
		hex_result_t want;
		int errs;
		errs = 0;
		if (expected_results.size() == 0) begin
			$error("result transfer with no result expected: status %0d byte %0d",
				res.status, res.payload_byte);
			fails <= fails + 1;
			return;
		end
		want = expected_results.pop_front();
		check_field("status", want.status, res.status, errs);
		check_field("payload_byte", want.payload_byte, res.payload_byte, errs);
		check_field("hex_high", want.hex_high, res.hex_high, errs);
		check_field("hex_low", want.hex_low, res.hex_low, errs);
		check_field("row", want.row, res.row, errs);
		check_field("column", want.column, res.column, errs);
		check_field("last", want.last, res.last, errs);
		if (errs != 0)
			fails <= fails + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code = START_MARKER_RST;
			end_code   = END_MARKER_RST;
			frame_open = 1'b0;
			fill       = 0;
			expected_results.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			// compare first: a result leaving now belongs to an older frame
			if (res.valid && res.ready)
				check_result();
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_START_MARKER: start_code = cfg.data;
					CFG_END_MARKER:   end_code   = cfg.data;
					default: ;
				endcase
			end
			if (rx.valid && rx.ready)
				take_byte(rx.rx_byte);
			pending <= expected_results.size();
		end
	end

endmodule

### verif/marker_frame_hex_formatter_test.sv
// ----------------------------------------------------------------------------
// Marker frame hex formatter testbench
// Sends directed and random marker framed byte streams under several marker
// settings, with random idling on both channels in most runs, and reports the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module marker_frame_hex_formatter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mfhf_pkg::*;

	localparam int FRAME_DEPTH   = 64;
	localparam int BYTES_PER_ROW = 8;
	localparam int DISPLAY_ROWS  = 5;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mfhf_cfg_if cfg_ch ();
	mfhf_rx_if  rx_ch ();
	mfhf_res_if res_ch ();

	int          fails;
	int          pending;
	int          items_sent;
	int          cycle_count;
	bit          idling_on;
	logic [7:0]  start_code;
	logic [7:0]  end_code;
	int unsigned boundary_lens [5] = '{39, 40, 41, 61, 62};

	marker_frame_hex_formatter #(
		.FRAME_DEPTH   (FRAME_DEPTH),
		.BYTES_PER_ROW (BYTES_PER_ROW),
		.DISPLAY_ROWS  (DISPLAY_ROWS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	marker_frame_hex_formatter_checker #(
		.FRAME_DEPTH   (FRAME_DEPTH),
		.BYTES_PER_ROW (BYTES_PER_ROW),
		.DISPLAY_ROWS  (DISPLAY_ROWS)
	) checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.rx      (rx_ch),
		.res     (res_ch),
		.fails   (fails),
		.pending (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result sink: random stall bursts while idling is on
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_START_MARKER)
			start_code = value;
		else if (idx == CFG_END_MARKER)
			end_code = value;
	endtask

	task automatic send_byte(input logic [7:0] b);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		items_sent++;
	endtask

	// byte that is neither marker
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == start_code || b == end_code);
		return b;
	endfunction

	task automatic send_frame(input int unsigned len, input bit closed);
		send_byte(start_code);
		repeat (len) send_byte(plain_byte());
		if (closed)
			send_byte(end_code);
	endtask

	// hold the input and let every expected result drain
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int quota);
		int stop_at;
		int sel;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 55)
				send_frame($urandom_range(0, 10), 1'b1);
			else if (sel < 70)
				send_frame($urandom_range(11, 40), 1'b1);
			else if (sel < 74)
				send_frame(boundary_lens[$urandom_range(0, 4)], 1'b1);
			else if (sel < 76)
				send_frame($urandom_range(42, 70), 1'b1);
			else if (sel < 86)
				send_frame($urandom_range(0, 6), 1'b0);
			else
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = CFG_START_MARKER;
		cfg_ch.data   = 8'h00;
		start_code    = START_MARKER_RST;
		end_code      = END_MARKER_RST;
		idling_on     = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_START_MARKER, START_MARKER_RST);
		write_reg(CFG_END_MARKER, END_MARKER_RST);

		// a byte and an end marker with no frame open
		send_byte(8'h00);
		send_byte(end_code);
		// empty frame
		send_byte(start_code);
		send_byte(end_code);
		// value extremes and both digit ranges
		send_byte(start_code);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_byte(8'h3C);
		send_byte(8'h9B);
		send_byte(end_code);
		// start marker restarts an open frame
		send_byte(start_code);
		send_byte(8'h12);
		send_byte(start_code);
		send_byte(8'h34);
		send_byte(end_code);
		// second end marker finds no frame open
		send_byte(start_code);
		send_byte(end_code);
		send_byte(end_code);
		drain();

		run_random(60);
		drain();

		// equal markers: the byte always counts as a start
		write_reg(CFG_START_MARKER, 8'h7E);
		write_reg(CFG_END_MARKER, 8'h7E);
		send_byte(8'h7E);
		send_byte(8'h01);
		send_byte(8'h7E);
		send_byte(8'h02);
		send_byte(8'h7E);
		run_random(10);
		drain();

		write_reg(CFG_START_MARKER, 8'h00);
		write_reg(CFG_END_MARKER, 8'hFF);
		run_random(50);
		drain();

		write_reg(CFG_START_MARKER, 8'hFF);
		write_reg(CFG_END_MARKER, 8'h00);
		run_random(50);
		drain();

		write_reg(CFG_START_MARKER, 8'($urandom_range(0, 255)));
		write_reg(CFG_END_MARKER, 8'($urandom_range(0, 255)));
		idling_on = 1'b0;
		run_random(40);
		drain();

		if (fails == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
